FILE: hdl/cta_pkg.sv
// ----------------------------------------------------------------------------
// Cluster template averager package
// Shared widths, codes and types of the cluster template averager.
// ----------------------------------------------------------------------------
package cta_pkg;

    localparam int unsigned DEFAULT_MAX_CLIP_SAMPLES = 256;
    localparam int unsigned DEFAULT_MAX_CLUSTERS     = 64;

    localparam int unsigned LABEL_W    = 7;
    localparam int unsigned POS_W      = 8;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned MEAN_W     = 16;
    localparam int unsigned COUNT_W    = 20;
    localparam int unsigned SUM_W      = 36;
    localparam int unsigned CLIP_LEN_W = 9;

    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 40;

    localparam logic [CLIP_LEN_W-1:0] CLIP_LEN_RESET = 9'd256;
    localparam logic [COUNT_W-1:0]    COUNT_MAX      = 20'hFFFFF;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic [MEAN_W-1:0] MEAN_MAX = 16'h7FFF;
    localparam logic [MEAN_W-1:0] MEAN_MIN = 16'h8000;

    localparam int unsigned DIV_STEPS = SUM_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [0:0] {
        OP_ACCUMULATE = 1'b0,
        OP_READ       = 1'b1
    } opcode_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic int unsigned addr_width(input int unsigned depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

FILE: hdl/cta_ram.sv
// ----------------------------------------------------------------------------
// Cluster template averager RAM
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module cta_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [cta_pkg::addr_width(DEPTH)-1:0]      waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [cta_pkg::addr_width(DEPTH)-1:0]      raddr,
    output logic [WIDTH-1:0]                            rdata
);
    import cta_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/cta_div.sv
// ----------------------------------------------------------------------------
// Cluster template averager divider
// Iterative restoring divider, one quotient bit per cycle, with the signed
// quotient truncated toward zero and saturated to the mean range.
// ----------------------------------------------------------------------------
module cta_div (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [cta_pkg::SUM_W-1:0]        dividend,
    input  logic [cta_pkg::COUNT_W-1:0]             divisor,
    output cta_pkg::div_status_t                    status,
    output logic [cta_pkg::MEAN_W-1:0]              quotient
);
    import cta_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic [COUNT_W:0]       rem_reg, rem_next;
    logic [SUM_W-1:0]       quo_reg, quo_next;
    logic [COUNT_W-1:0]     div_reg, div_next;
    logic [MEAN_W-1:0]      res_reg, res_next;

    logic [COUNT_W:0]       rem_shift;
    logic                   fits;
    logic [SUM_W-1:0]       quo_step;

    always_comb
    begin
        rem_shift = {rem_reg[COUNT_W-1:0], quo_reg[SUM_W-1]};
        fits      = rem_shift >= {1'b0, div_reg};
        quo_step  = {quo_reg[SUM_W-2:0], fits};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        res_next  = res_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[SUM_W-1];
            rem_next  = '0;
            quo_next  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (rem_shift - {1'b0, div_reg}) : rem_shift;
            quo_next = quo_step;
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg)
                begin
                    if (quo_step > SUM_W'(32768))
                    begin
                        res_next = MEAN_MIN;
                    end
                    else
                    begin
                        res_next = MEAN_W'(-quo_step[MEAN_W-1:0]);
                    end
                end
                else
                begin
                    if (quo_step > SUM_W'(32767))
                    begin
                        res_next = MEAN_MAX;
                    end
                    else
                    begin
                        res_next = quo_step[MEAN_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        res_reg <= res_next;
    end

    assign status   = {busy_reg, done_reg};
    assign quotient = res_reg;

endmodule

FILE: hdl/cluster_template_averager_core.sv
// ----------------------------------------------------------------------------
// Cluster template averager core
// Builds per-cluster mean waveforms from labelled clip samples and answers
// mean reads through a shared iterative divider.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one transaction per item. tuser is the opcode:
// 0 adds the sample into the cluster's sum at the given position, 1 reads
// the template mean and clip count for a cluster and position. Accumulate
// transactions produce nothing on the master stream; each read produces
// exactly one master transaction.
// An accumulate reads the sum and count memories on acceptance and then
// writes back the updated sum, and the count on a clip's last position.
// A read of a nonempty cluster passes through the 36-step divider before
// its result is loaded; a read answered with a zero mean bypasses it.
// After reset the block sweeps both memories to zero, one entry per cycle,
// over all MAX_CLUSTERS * MAX_CLIP_SAMPLES sum entries (16384 by default),
// with s_axis_tready low. The clip length register can be written at any time.
// The result sits in an output register; a stalled receiver only holds up
// the next read once its divide has finished.
// ----------------------------------------------------------------------------
module cluster_template_averager_core #(
    parameter int unsigned MAX_CLIP_SAMPLES = cta_pkg::DEFAULT_MAX_CLIP_SAMPLES,
    parameter int unsigned MAX_CLUSTERS     = cta_pkg::DEFAULT_MAX_CLUSTERS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // cluster_label [6:0], sample_position [14:7], sample_value [30:15]
    input  logic [cta_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // opcode [0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // mean_value [15:0], clip_count [35:16]
    output logic [cta_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    input  logic                                clip_length_wr_en,
    input  logic [cta_pkg::CLIP_LEN_W-1:0]      clip_length_wr_data
);
    import cta_pkg::*;

    localparam int unsigned SUM_DEPTH = MAX_CLUSTERS * MAX_CLIP_SAMPLES;
    localparam int unsigned SA_W      = addr_width(SUM_DEPTH);
    localparam int unsigned CL_W      = addr_width(MAX_CLUSTERS);
    localparam int unsigned LEN_W     = $clog2(MAX_CLIP_SAMPLES + 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_DIV   = 5'b01000,
        S_LOAD  = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [SA_W-1:0]            clr_addr_reg, clr_addr_next;
    logic [CLIP_LEN_W-1:0]      clip_length_reg;

    opcode_t                    op_reg;
    logic [SAMPLE_W-1:0]        sample_reg;
    logic [SA_W-1:0]            sum_addr_reg;
    logic [CL_W-1:0]            k_reg;
    logic                       acc_ok_reg;
    logic                       last_reg;
    logic                       label_ok_reg;
    logic                       in_store_reg;

    logic [COUNT_W-1:0]         res_count_reg, res_count_next;
    logic                       res_zero_reg, res_zero_next;

    logic                       m_valid_reg;
    logic [MEAN_W-1:0]          out_mean_reg;
    logic [COUNT_W-1:0]         out_count_reg;

    logic [LABEL_W-1:0]         label_in;
    logic [POS_W-1:0]           pos_in;
    logic [CL_W-1:0]            k_in;
    logic [SA_W-1:0]            sum_raddr;
    logic [LEN_W-1:0]           len_eff;
    logic                       accept;
    logic                       label_ok_in;
    logic                       pos_in_len;

    logic                       sum_we;
    logic [SA_W-1:0]            sum_waddr;
    logic [SUM_W-1:0]           sum_wdata;
    logic [SUM_W-1:0]           sum_rdata;
    logic                       cnt_we;
    logic [CL_W-1:0]            cnt_waddr;
    logic [COUNT_W-1:0]         cnt_wdata;
    logic [COUNT_W-1:0]         cnt_rdata;

    logic signed [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]           sum_sat;

    logic                       div_start;
    div_status_t                div_stat;
    logic [MEAN_W-1:0]          div_quot;
    logic                       load_ok;

    assign label_in = s_axis_tdata[LABEL_W-1:0];
    assign pos_in   = s_axis_tdata[LABEL_W+POS_W-1:LABEL_W];
    assign k_in     = CL_W'(label_in - LABEL_W'(1));
    assign sum_raddr = SA_W'(32'(k_in) * MAX_CLIP_SAMPLES + 32'(pos_in));
    assign accept   = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (clip_length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(clip_length_reg) > MAX_CLIP_SAMPLES)
        begin
            len_eff = LEN_W'(MAX_CLIP_SAMPLES);
        end
        else
        begin
            len_eff = LEN_W'(clip_length_reg);
        end
    end

    assign label_ok_in = (label_in != '0) && (32'(label_in) <= MAX_CLUSTERS);
    assign pos_in_len  = 32'(pos_in) < 32'(len_eff);

    assign sum_wide = $signed({sum_rdata[SUM_W-1], sum_rdata})
                    + $signed({{(SUM_W+1-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg});

    always_comb
    begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    assign load_ok = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        res_count_next = res_count_reg;
        res_zero_next  = res_zero_reg;
        sum_we         = 1'b0;
        sum_waddr      = sum_addr_reg;
        sum_wdata      = sum_sat;
        cnt_we         = 1'b0;
        cnt_waddr      = k_reg;
        cnt_wdata      = cnt_rdata + COUNT_W'(1);
        div_start      = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                sum_we    = 1'b1;
                sum_waddr = clr_addr_reg;
                sum_wdata = '0;
                cnt_we    = 32'(clr_addr_reg) < MAX_CLUSTERS;
                cnt_waddr = CL_W'(clr_addr_reg);
                cnt_wdata = '0;
                clr_addr_next = clr_addr_reg + SA_W'(1);
                if (32'(clr_addr_reg) == SUM_DEPTH - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (op_reg == OP_ACCUMULATE)
                begin
                    sum_we     = acc_ok_reg;
                    cnt_we     = acc_ok_reg && last_reg && (cnt_rdata != COUNT_MAX);
                    state_next = S_IDLE;
                end
                else
                begin
                    res_count_next = label_ok_reg ? cnt_rdata : '0;
                    if (label_ok_reg && in_store_reg && (cnt_rdata != '0))
                    begin
                        res_zero_next = 1'b0;
                        div_start     = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        res_zero_next = 1'b1;
                        state_next    = S_LOAD;
                    end
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (load_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            clip_length_reg <= CLIP_LEN_RESET;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            if (clip_length_wr_en)
            begin
                clip_length_reg <= clip_length_wr_data;
            end
            if (state_reg == S_LOAD && load_ok)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_count_reg <= res_count_next;
        res_zero_reg  <= res_zero_next;
        if (accept)
        begin
            op_reg       <= opcode_t'(s_axis_tuser);
            sample_reg   <= s_axis_tdata[LABEL_W+POS_W+SAMPLE_W-1:LABEL_W+POS_W];
            sum_addr_reg <= sum_raddr;
            k_reg        <= k_in;
            acc_ok_reg   <= label_ok_in && pos_in_len;
            last_reg     <= 32'(pos_in) == 32'(len_eff) - 1;
            label_ok_reg <= label_ok_in;
            in_store_reg <= 32'(pos_in) < MAX_CLIP_SAMPLES;
        end
        if (state_reg == S_LOAD && load_ok)
        begin
            out_mean_reg  <= res_zero_reg ? '0 : div_quot;
            out_count_reg <= res_count_reg;
        end
    end

    cta_ram #(
        .WIDTH (SUM_W),
        .DEPTH (SUM_DEPTH)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .re    (accept),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    cta_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_CLUSTERS)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (accept),
        .raddr (k_in),
        .rdata (cnt_rdata)
    );

    cta_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ($signed(sum_rdata)),
        .divisor  (cnt_rdata),
        .status   (div_stat),
        .quotient (div_quot)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-MEAN_W-COUNT_W){1'b0}}, out_count_reg, out_mean_reg};

    a_div_start_idle : assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_done_state : assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    a_sum_write_state : assert property (@(posedge clk) disable iff (!rst_n)
        sum_we |-> (state_reg == S_CLEAR || state_reg == S_EXEC))
        else $error("sum memory written outside clear or update");

    a_accept_after_clear : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (state_reg != S_CLEAR) && !div_stat.busy)
        else $error("transaction accepted while clearing or dividing");

endmodule
